/* design/scom_pkg.sv */
// Seam colour offset match: shared types, widths and command codes.
// Used by the interfaces, the lane and the top level. No dependencies.
package scom_pkg;

  // Pixel and register widths
  localparam int PIX_W   = 8;
  localparam int CMD_W   = 3;
  localparam int CNT_CFG_W = 7;
  localparam int SIZE_CFG_W = 13;
  localparam int CFG_IDX_W = 3;

  // Accumulator widths (sized for the default image limits)
  localparam int SUM_W   = 25;
  localparam int CNT_W   = 18;
  localparam int OFF_W   = 18;
  localparam int PROD_W  = SUM_W + CNT_W;
  localparam int DEN_W   = 2 * CNT_W;
  localparam int QW      = 17;
  localparam int REM_W   = DEN_W + QW;
  localparam int SH_W    = 5;

  // Commands
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SAMPLE_L = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SAMPLE_R = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FINISH   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ADJUST_L = 3'd4;
  localparam logic [CMD_W-1:0] CMD_ADJUST_R = 3'd5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_HEIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_HEIGHT = 3'd4;

  // Result kinds and status
  localparam logic RES_REPORT = 1'b0;
  localparam logic RES_PIXEL  = 1'b1;
  localparam logic STAT_OK    = 1'b0;
  localparam logic STAT_EMPTY = 1'b1;

  // Control from the sequencer to each colour lane
  typedef struct packed {
    logic            clear;
    logic            add_left;
    logic            add_right;
    logic            fin_init;
    logic            mul_en;
    logic            rn_bit;
    logic            ln_bit;
    logic            prep;
    logic            div_en;
    logic            fin_done;
    logic            err;
    logic            adj_sub;
    logic [SH_W-1:0] shift;
  } lane_ctl_t;

endpackage

/* design/scom_if.sv */
// Seam colour offset match: item, result and register write channels.
// Depends on scom_pkg for field widths.
interface scom_in_if;
  logic                            valid;
  logic                            ready;
  logic [scom_pkg::CMD_W-1:0]      command;
  logic [scom_pkg::PIX_W-1:0]      red;
  logic [scom_pkg::PIX_W-1:0]      green;
  logic [scom_pkg::PIX_W-1:0]      blue;
  logic [scom_pkg::PIX_W-1:0]      mask_value;
  logic                            mask_inside;
  modport source (output valid, command, red, green, blue, mask_value, mask_inside,
                  input ready);
  modport sink (input valid, command, red, green, blue, mask_value, mask_inside,
                output ready);
endinterface

interface scom_out_if;
  logic                               valid;
  logic                               ready;
  logic                               result_kind;
  logic                               status;
  logic signed [scom_pkg::OFF_W-1:0]  offset_red;
  logic signed [scom_pkg::OFF_W-1:0]  offset_green;
  logic signed [scom_pkg::OFF_W-1:0]  offset_blue;
  logic [scom_pkg::PIX_W-1:0]         out_red;
  logic [scom_pkg::PIX_W-1:0]         out_green;
  logic [scom_pkg::PIX_W-1:0]         out_blue;
  modport source (output valid, result_kind, status, offset_red, offset_green, offset_blue,
                  out_red, out_green, out_blue, input ready);
  modport sink (input valid, result_kind, status, offset_red, offset_green, offset_blue,
                out_red, out_green, out_blue, output ready);
endinterface

interface scom_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [scom_pkg::CFG_IDX_W-1:0]      index;
  logic [scom_pkg::SIZE_CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* design/seam_color_offset_match_top.sv */
// Seam colour offset match: top level with sequencer, line RAM, three colour
// lanes and the result register. Depends on scom_pkg, scom_if, scom_ram, scom_lane.
//
// Usage: items arrive on req (valid/ready); results leave on rsp (valid/ready);
// registers are written on cfg, which is always ready. Send sample items of
// the left image, then of the right image, in raster order, then a finish
// item, which reports the per-channel offsets (or status 1 when a side had
// no samples). Adjust items then return corrected pixels.
// Timing: each item is taken in one cycle and worked on in the next. The
// seam pixel of a left row then sums the stored pixels (up to sample_count)
// as the line RAM is read back one entry a cycle. Adjust goes through the
// execute and push states. Finish runs 18 shift-add steps for the products,
// one setup, 17 division steps, rounding and output. One item is in work at
// a time; the next is taken while a finished result still waits in the
// output register.
// Reset clears the sequencer state, lane sums, offsets and result valid flag
// and sets the registers to their defaults. When the receiver stalls, a result
// holds in the output register; the next result-producing item waits to load it.
module seam_color_offset_match_top #(
  parameter int MAX_SAMPLES = 64,
  parameter int MAX_WIDTH   = 4096,
  parameter int MAX_HEIGHT  = 4096
) (
  input logic        clk,
  input logic        rst,
  scom_in_if.sink    req,
  scom_out_if.source rsp,
  scom_cfg_if.sink   cfg
);
  localparam int N_W   = $clog2(MAX_SAMPLES + 1);
  localparam int P_W   = MAX_SAMPLES > 1 ? $clog2(MAX_SAMPLES) : 1;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int W_W   = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int H_W   = $clog2(MAX_HEIGHT + 1);
  localparam int CW    = scom_pkg::CNT_W;
  localparam int PX    = scom_pkg::PIX_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_LSUM  = 3'd2;
  localparam logic [2:0] S_FMUL  = 3'd3;
  localparam logic [2:0] S_FPREP = 3'd4;
  localparam logic [2:0] S_FDIV  = 3'd5;
  localparam logic [2:0] S_FRND  = 3'd6;
  localparam logic [2:0] S_PUSH  = 3'd7;

  // Registers
  logic [scom_pkg::CNT_CFG_W-1:0]  cfg_n;
  logic [scom_pkg::SIZE_CFG_W-1:0] cfg_lw, cfg_lh, cfg_rw, cfg_rh;

  logic [scom_pkg::CMD_W-1:0] it_cmd;
  logic [PX-1:0]              it_r, it_g, it_b, it_mval;
  logic                       it_inside;

  logic [2:0]                 state, state_next;
  logic [ROW_W-1:0]           row, row_next;
  logic [COL_W-1:0]           col, col_next;
  logic [P_W-1:0]             ptr, ptr_next;
  logic                       seen, seen_next;
  logic [N_W-1:0]             rrem, rrem_next;
  logic                       side, side_next;
  logic [CW-1:0]              lcnt, lcnt_next, rcnt, rcnt_next;
  logic [scom_pkg::DEN_W-1:0] den, den_next;
  logic [scom_pkg::SH_W-1:0]  step, step_next;
  logic [N_W-1:0]             loop_cnt, loop_cnt_next;
  logic [P_W-1:0]             rd_addr, rd_addr_next;
  logic                       fin_err, fin_err_next;

  logic                       out_valid;
  logic                       out_load;

  // RAM and lane signals
  logic                 ram_we;
  logic [P_W-1:0]       ram_raddr;
  logic [3*PX-1:0]      ram_rdata;
  scom_pkg::lane_ctl_t  ctl;
  logic signed [scom_pkg::OFF_W-1:0] off_r, off_g, off_b;
  logic [PX-1:0]        adj_r, adj_g, adj_b;

  // Effective sizes and sample count
  logic [N_W-1:0] n_eff;
  logic [W_W-1:0] lw_eff, rw_eff;
  logic [H_W-1:0] lh_eff, rh_eff;

  always_comb begin
    n_eff  = (32'(cfg_n) > 32'(MAX_SAMPLES)) ? N_W'(MAX_SAMPLES) : N_W'(cfg_n);
    lw_eff = (cfg_lw == '0) ? W_W'(1) :
             (32'(cfg_lw) > 32'(MAX_WIDTH)) ? W_W'(MAX_WIDTH) : W_W'(cfg_lw);
    rw_eff = (cfg_rw == '0) ? W_W'(1) :
             (32'(cfg_rw) > 32'(MAX_WIDTH)) ? W_W'(MAX_WIDTH) : W_W'(cfg_rw);
    lh_eff = (cfg_lh == '0) ? H_W'(1) :
             (32'(cfg_lh) > 32'(MAX_HEIGHT)) ? H_W'(MAX_HEIGHT) : H_W'(cfg_lh);
    rh_eff = (cfg_rh == '0) ? H_W'(1) :
             (32'(cfg_rh) > 32'(MAX_HEIGHT)) ? H_W'(MAX_HEIGHT) : H_W'(cfg_rh);
  end

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_n  <= 7'd8;
      cfg_lw <= 13'd4096;
      cfg_lh <= 13'd4096;
      cfg_rw <= 13'd4096;
      cfg_rh <= 13'd4096;
    end else if (cfg.valid) begin
      case (cfg.index)
        scom_pkg::REG_SAMPLE_COUNT: cfg_n  <= cfg.data[scom_pkg::CNT_CFG_W-1:0];
        scom_pkg::REG_LEFT_WIDTH:   cfg_lw <= cfg.data;
        scom_pkg::REG_LEFT_HEIGHT:  cfg_lh <= cfg.data;
        scom_pkg::REG_RIGHT_WIDTH:  cfg_rw <= cfg.data;
        scom_pkg::REG_RIGHT_HEIGHT: cfg_rh <= cfg.data;
        default: ;
      endcase
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      it_cmd    <= req.command;
      it_r      <= req.red;
      it_g      <= req.green;
      it_b      <= req.blue;
      it_mval   <= req.mask_value;
      it_inside <= req.mask_inside;
    end
  end

  // Sequencer
  logic              b_right, is_seam, in_band, do_adv, a_seen;
  logic [ROW_W-1:0]  b_row, a_row;
  logic [COL_W-1:0]  b_col, a_col;
  logic [P_W-1:0]    b_ptr, a_ptr;
  logic              b_seen;
  logic [N_W-1:0]    b_rrem, a_rrem, take;
  logic [W_W-1:0]    cur_w;
  logic [H_W-1:0]    cur_h;
  logic [H_W+1:0]    h3;

  always_comb begin
    state_next    = state;
    row_next      = row;
    col_next      = col;
    ptr_next      = ptr;
    seen_next     = seen;
    rrem_next     = rrem;
    side_next     = side;
    lcnt_next     = lcnt;
    rcnt_next     = rcnt;
    den_next      = den;
    step_next     = step;
    loop_cnt_next = loop_cnt;
    rd_addr_next  = rd_addr;
    fin_err_next  = fin_err;
    ctl           = '0;
    ctl.adj_sub   = (it_cmd == scom_pkg::CMD_ADJUST_L);
    ram_we        = 1'b0;
    ram_raddr     = rd_addr;
    out_load      = 1'b0;
    do_adv        = 1'b0;

    b_right = (it_cmd == scom_pkg::CMD_SAMPLE_R);
    b_row   = row;
    b_col   = col;
    b_ptr   = ptr;
    b_seen  = seen;
    b_rrem  = rrem;
    if (b_right != side) begin
      b_row  = '0;
      b_col  = '0;
      b_ptr  = '0;
      b_seen = 1'b0;
      b_rrem = '0;
    end
    cur_w   = b_right ? rw_eff : lw_eff;
    cur_h   = b_right ? rh_eff : lh_eff;
    h3      = (H_W + 2)'(cur_h) * (H_W + 2)'(3);
    in_band = (32'(b_row) >= 32'(cur_h >> 2)) && (32'(b_row) < 32'(h3 >> 2));
    is_seam = it_inside && (it_mval == 8'd1);
    take    = (32'(b_col) < 32'(n_eff)) ? N_W'(b_col) : n_eff;
    a_row   = b_row;
    a_col   = b_col;
    a_ptr   = b_ptr;
    a_seen  = b_seen;
    a_rrem  = b_rrem;

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (it_cmd)
          scom_pkg::CMD_CLEAR: begin
            ctl.clear  = 1'b1;
            row_next   = '0;
            col_next   = '0;
            ptr_next   = '0;
            seen_next  = 1'b0;
            rrem_next  = '0;
            side_next  = 1'b0;
            lcnt_next  = '0;
            rcnt_next  = '0;
            state_next = S_IDLE;
          end
          scom_pkg::CMD_SAMPLE_L, scom_pkg::CMD_SAMPLE_R: begin
            side_next  = b_right;
            state_next = S_IDLE;
            do_adv     = 1'b1;
            if (in_band) begin
              if (!b_right) begin
                if (!b_seen && is_seam) begin
                  a_seen    = 1'b1;
                  lcnt_next = lcnt + CW'(take);
                  if (take != '0) begin
                    // sum stored pixels back from the seam, one a cycle
                    do_adv        = 1'b0;
                    row_next      = b_row;
                    col_next      = b_col;
                    ptr_next      = b_ptr;
                    seen_next     = 1'b1;
                    rrem_next     = b_rrem;
                    loop_cnt_next = take;
                    ram_raddr     = (b_ptr == '0) ? P_W'(MAX_SAMPLES - 1) : b_ptr - P_W'(1);
                    rd_addr_next  = ram_raddr;
                    state_next    = S_LSUM;
                  end
                end
              end else begin
                if (!b_seen && is_seam) begin
                  a_seen = 1'b1;
                  a_rrem = n_eff;
                end
                if (a_rrem != '0) begin
                  ctl.add_right = 1'b1;
                  rcnt_next     = rcnt + CW'(1);
                  a_rrem        = a_rrem - N_W'(1);
                end
              end
            end
          end
          scom_pkg::CMD_FINISH: begin
            fin_err_next = (lcnt == '0) || (rcnt == '0);
            if ((lcnt == '0) || (rcnt == '0)) begin
              ctl.fin_done = 1'b1;
              ctl.err      = 1'b1;
              row_next     = '0;
              col_next     = '0;
              ptr_next     = '0;
              seen_next    = 1'b0;
              rrem_next    = '0;
              side_next    = 1'b0;
              lcnt_next    = '0;
              rcnt_next    = '0;
              state_next   = S_PUSH;
            end else begin
              ctl.fin_init = 1'b1;
              den_next     = '0;
              step_next    = '0;
              state_next   = S_FMUL;
            end
          end
          scom_pkg::CMD_ADJUST_L, scom_pkg::CMD_ADJUST_R: begin
            state_next = S_PUSH;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_LSUM: begin
        ctl.add_left  = 1'b1;
        loop_cnt_next = loop_cnt - N_W'(1);
        a_row   = row;
        a_col   = col;
        a_ptr   = ptr;
        a_seen  = seen;
        a_rrem  = rrem;
        cur_w   = lw_eff;
        cur_h   = lh_eff;
        if (loop_cnt == N_W'(1)) begin
          do_adv     = 1'b1;
          state_next = S_IDLE;
        end else begin
          ram_raddr    = (rd_addr == '0) ? P_W'(MAX_SAMPLES - 1) : rd_addr - P_W'(1);
          rd_addr_next = ram_raddr;
        end
      end
      S_FMUL: begin
        ctl.mul_en = 1'b1;
        ctl.shift  = step;
        ctl.rn_bit = rcnt[step];
        ctl.ln_bit = lcnt[step];
        den_next   = den + (rcnt[step] ? (scom_pkg::DEN_W'(lcnt) << step) : '0);
        if (step == scom_pkg::SH_W'(CW - 1)) begin
          state_next = S_FPREP;
        end else begin
          step_next = step + scom_pkg::SH_W'(1);
        end
      end
      S_FPREP: begin
        ctl.prep   = 1'b1;
        step_next  = scom_pkg::SH_W'(scom_pkg::QW - 1);
        state_next = S_FDIV;
      end
      S_FDIV: begin
        ctl.div_en = 1'b1;
        ctl.shift  = step;
        if (step == '0) begin
          state_next = S_FRND;
        end else begin
          step_next = step - scom_pkg::SH_W'(1);
        end
      end
      S_FRND: begin
        ctl.fin_done = 1'b1;
        row_next     = '0;
        col_next     = '0;
        ptr_next     = '0;
        seen_next    = 1'b0;
        rrem_next    = '0;
        side_next    = 1'b0;
        lcnt_next    = '0;
        rcnt_next    = '0;
        state_next   = S_PUSH;
      end
      S_PUSH: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    // Store the pixel and step the raster position
    if (do_adv) begin
      ram_we = 1'b1;
      if (32'(a_col) + 32'd1 >= 32'(cur_w)) begin
        col_next  = '0;
        ptr_next  = '0;
        seen_next = 1'b0;
        rrem_next = '0;
        row_next  = (32'(a_row) + 32'd1 >= 32'(cur_h)) ? '0 : a_row + ROW_W'(1);
      end else begin
        col_next  = a_col + COL_W'(1);
        ptr_next  = (a_ptr == P_W'(MAX_SAMPLES - 1)) ? '0 : a_ptr + P_W'(1);
        seen_next = a_seen;
        rrem_next = a_rrem;
        row_next  = a_row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      row      <= '0;
      col      <= '0;
      ptr      <= '0;
      seen     <= 1'b0;
      rrem     <= '0;
      side     <= 1'b0;
      lcnt     <= '0;
      rcnt     <= '0;
      step     <= '0;
      loop_cnt <= '0;
      fin_err  <= 1'b0;
    end else begin
      state    <= state_next;
      row      <= row_next;
      col      <= col_next;
      ptr      <= ptr_next;
      seen     <= seen_next;
      rrem     <= rrem_next;
      side     <= side_next;
      lcnt     <= lcnt_next;
      rcnt     <= rcnt_next;
      step     <= step_next;
      loop_cnt <= loop_cnt_next;
      fin_err  <= fin_err_next;
    end
  end

  always_ff @(posedge clk) begin
    den     <= den_next;
    rd_addr <= rd_addr_next;
  end

  // Line RAM of recent pixels, indexed by column mod MAX_SAMPLES
  scom_ram #(.WIDTH(3 * PX), .DEPTH(MAX_SAMPLES)) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (a_ptr),
    .wdata ({it_b, it_g, it_r}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Colour lanes
  scom_lane u_lane_r (
    .clk (clk), .rst (rst), .ctl (ctl), .pixel (it_r), .hist (ram_rdata[PX-1:0]),
    .den (den), .offset (off_r), .adjusted (adj_r)
  );
  scom_lane u_lane_g (
    .clk (clk), .rst (rst), .ctl (ctl), .pixel (it_g), .hist (ram_rdata[2*PX-1:PX]),
    .den (den), .offset (off_g), .adjusted (adj_g)
  );
  scom_lane u_lane_b (
    .clk (clk), .rst (rst), .ctl (ctl), .pixel (it_b), .hist (ram_rdata[3*PX-1:2*PX]),
    .den (den), .offset (off_b), .adjusted (adj_b)
  );

  // Merge the lanes into the result register
  logic is_adj;
  assign is_adj = (it_cmd == scom_pkg::CMD_ADJUST_L) || (it_cmd == scom_pkg::CMD_ADJUST_R);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.result_kind  <= is_adj ? scom_pkg::RES_PIXEL : scom_pkg::RES_REPORT;
      rsp.status       <= (!is_adj && fin_err) ? scom_pkg::STAT_EMPTY : scom_pkg::STAT_OK;
      rsp.offset_red   <= off_r;
      rsp.offset_green <= off_g;
      rsp.offset_blue  <= off_b;
      rsp.out_red      <= is_adj ? adj_r : '0;
      rsp.out_green    <= is_adj ? adj_g : '0;
      rsp.out_blue     <= is_adj ? adj_b : '0;
    end
  end

  assign rsp.valid = out_valid;
endmodule

/* design/scom_ram.sv */
// Seam colour offset match: generic single-write RAM with registered read.
// No dependencies.
module scom_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* design/scom_lane.sv */
// Seam colour offset match: one colour lane. Holds the side sums, runs the
// shift-add products and restoring division at finish, and adjusts pixels.
// Depends on scom_pkg.
module scom_lane (
  input  logic                                clk,
  input  logic                                rst,
  input  scom_pkg::lane_ctl_t                 ctl,
  input  logic [scom_pkg::PIX_W-1:0]          pixel,
  input  logic [scom_pkg::PIX_W-1:0]          hist,
  input  logic [scom_pkg::DEN_W-1:0]          den,
  output logic signed [scom_pkg::OFF_W-1:0]   offset,
  output logic [scom_pkg::PIX_W-1:0]          adjusted
);
  localparam int PW = scom_pkg::PROD_W;
  localparam int RW = scom_pkg::REM_W;
  localparam int OW = scom_pkg::OFF_W;

  logic [scom_pkg::SUM_W-1:0] left_sum;
  logic [scom_pkg::SUM_W-1:0] right_sum;
  logic [PW-1:0]              prod_a;
  logic [PW-1:0]              prod_b;
  logic                       neg;
  logic [RW-1:0]              rem;
  logic [scom_pkg::QW-1:0]    quo;

  logic [PW-1:0]        ls_sh, rs_sh, mag;
  logic signed [PW:0]   diff;
  logic [RW-1:0]        dsh;
  logic                 ge;
  logic [RW:0]          twice_r;
  logic                 inc;
  logic [OW-1:0]        qr, rounded;

  // Shifted operands for the product and division steps
  assign ls_sh = PW'(left_sum) << ctl.shift;
  assign rs_sh = PW'(right_sum) << ctl.shift;
  assign diff  = $signed({1'b0, prod_a}) - $signed({1'b0, prod_b});
  assign mag   = diff[PW] ? PW'(-diff) : PW'(diff);
  assign dsh   = RW'(den) << ctl.shift;
  assign ge    = rem >= dsh;

  // Round half to even, then apply the sign
  assign twice_r = {rem, 1'b0};
  assign inc     = (twice_r > (RW + 1)'(den)) ||
                   ((twice_r == (RW + 1)'(den)) && quo[0]);
  assign qr      = OW'(quo) + OW'(inc);
  assign rounded = neg ? (~qr + OW'(1)) : qr;

  // Sums and stored offset
  always_ff @(posedge clk) begin
    if (rst) begin
      left_sum  <= '0;
      right_sum <= '0;
      offset    <= '0;
    end else if (ctl.clear) begin
      left_sum  <= '0;
      right_sum <= '0;
      offset    <= '0;
    end else begin
      if (ctl.add_left) begin
        left_sum <= left_sum + scom_pkg::SUM_W'(hist);
      end
      if (ctl.add_right) begin
        right_sum <= right_sum + scom_pkg::SUM_W'(pixel);
      end
      if (ctl.fin_done) begin
        left_sum  <= '0;
        right_sum <= '0;
        offset    <= ctl.err ? '0 : $signed(rounded);
      end
    end
  end

  // Finish datapath: products, then quotient bits MSB first
  always_ff @(posedge clk) begin
    if (ctl.fin_init) begin
      prod_a <= '0;
      prod_b <= '0;
      quo    <= '0;
    end
    if (ctl.mul_en) begin
      prod_a <= prod_a + (ctl.rn_bit ? ls_sh : '0);
      prod_b <= prod_b + (ctl.ln_bit ? rs_sh : '0);
    end
    if (ctl.prep) begin
      neg <= diff[PW];
      rem <= RW'(mag) << 8;
    end
    if (ctl.div_en) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      quo <= {quo[scom_pkg::QW-2:0], ge};
    end
  end

  // Pixel adjust: (512*p -/+ offset)/512, half-even, clamped
  logic signed [20:0] off_ext, delta, wv;
  logic [11:0]        aq;
  logic [8:0]         ar;
  logic [12:0]        aq1;

  always_comb begin
    off_ext = {{(21 - OW){offset[OW-1]}}, offset};
    delta   = ctl.adj_sub ? -off_ext : off_ext;
    wv      = $signed({4'b0, pixel, 9'b0}) + delta + 21'sd131072;
    if (wv < 0) begin
      wv = '0;
    end
    aq  = wv[20:9];
    ar  = wv[8:0];
    aq1 = {1'b0, aq} + 13'((ar > 9'd256) || ((ar == 9'd256) && aq[0]));
    if (aq1 < 13'd256) begin
      adjusted = '0;
    end else if (aq1 > 13'd511) begin
      adjusted = 8'd255;
    end else begin
      adjusted = aq1[7:0];
    end
  end
endmodule
